// ----- hw/rtl/sm3_pkg.sv -----
package sm3_pkg;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINAL  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_LEN,
    ST_OUT
  } state_t;

  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  localparam logic [31:0] T_LOW       = 32'h79cc4519;
  // high round constant already rotated left by 16, the first round that uses it
  localparam logic [31:0] T_HIGH_R16  = 32'h9d8a7a87;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [5:0]  LEN_POS     = 6'd56;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [5:0]  LOW_ROUNDS  = 6'd15;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] v);
    return v ^ rotl(v, 9) ^ rotl(v, 17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] v);
    return v ^ rotl(v, 15) ^ rotl(v, 23);
  endfunction

endpackage

// ----- hw/rtl/sm3_front.sv -----
module sm3_front #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sm3_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output sm3_pkg::item_t q_item
);
  import sm3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           push, pop;

  assign in_ready = (count_r != CW'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

endmodule

// ----- hw/rtl/sm3_core.sv -----
module sm3_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  sm3_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_digest_word,
  output logic [2:0]     out_word_index,
  output logic           out_last_word
);
  import sm3_pkg::*;

  state_t      state_r, state_nxt, after_r;
  logic [31:0] win_r [16];
  logic [31:0] cv_r  [8];
  logic [31:0] v_r   [8];
  logic [31:0] newv  [8];
  logic [31:0] pad_w [16];
  logic [5:0]  fill_r, rnd_r;
  logic [63:0] len_r;
  logic [31:0] tj_r;
  logic [2:0]  widx_r;

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wnew;
  logic        low;
  logic        take, start, last_rnd;

  // round datapath
  always_comb begin
    low  = (rnd_r[5:4] == 2'b00);
    a12  = rotl(v_r[0], 12);
    ss1  = rotl(a12 + v_r[4] + tj_r, 7);
    ss2  = ss1 ^ a12;
    ff   = low ? (v_r[0] ^ v_r[1] ^ v_r[2])
               : ((v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]));
    gg   = low ? (v_r[4] ^ v_r[5] ^ v_r[6]) : ((v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]));
    tt1  = ff + v_r[3] + ss2 + (win_r[0] ^ win_r[4]);
    tt2  = gg + v_r[7] + ss1 + win_r[0];
    newv[0] = tt1;
    newv[1] = v_r[0];
    newv[2] = rotl(v_r[1], 9);
    newv[3] = v_r[2];
    newv[4] = p0(tt2);
    newv[5] = v_r[4];
    newv[6] = rotl(v_r[5], 19);
    newv[7] = v_r[6];
    wnew = p1(win_r[0] ^ win_r[7] ^ rotl(win_r[13], 15)) ^ rotl(win_r[3], 7) ^ win_r[10];
  end

  // padded block: pad byte, zeros after it, length unless it does not fit
  always_comb begin
    for (int b = 0; b < 64; b++) begin
      if (6'(b) == fill_r) begin
        pad_w[b / 4][(31 - 8 * (b % 4)) -: 8] = PAD_BYTE;
      end else if (6'(b) > fill_r) begin
        pad_w[b / 4][(31 - 8 * (b % 4)) -: 8] = 8'h00;
      end else begin
        pad_w[b / 4][(31 - 8 * (b % 4)) -: 8] = win_r[b / 4][(31 - 8 * (b % 4)) -: 8];
      end
    end
    if (fill_r < LEN_POS) begin
      pad_w[14] = len_r[63:32];
      pad_w[15] = len_r[31:0];
    end
  end

  assign last_rnd = (rnd_r == LAST_ROUND);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    take      = 1'b0;
    start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          take = 1'b1;
          if (q_item.operation == OP_FINAL) begin
            start     = 1'b1;
            state_nxt = ST_ROUND;
          end else if (fill_r == LAST_ROUND) begin
            start     = 1'b1;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (last_rnd) begin
          state_nxt = after_r;
        end
      end
      ST_LEN: begin
        start     = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_OUT: begin
        if (out_ready && widx_r == 3'd7) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign q_pop           = take;
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = cv_r[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      after_r <= ST_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      rnd_r   <= '0;
      widx_r  <= '0;
      cv_r    <= SM3_IV;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        rnd_r <= '0;
        v_r   <= cv_r;
        tj_r  <= T_LOW;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            if (q_item.operation == OP_ABSORB) begin
              win_r[fill_r[5:2]][(5'd31 - {fill_r[1:0], 3'b000}) -: 8] <= q_item.data_byte;
              fill_r  <= fill_r + 1'b1;
              len_r   <= len_r + 64'd8;
              after_r <= ST_IDLE;
            end else begin
              for (int i = 0; i < 16; i++) begin
                win_r[i] <= pad_w[i];
              end
              if (fill_r >= LEN_POS) begin
                after_r <= ST_LEN;
              end else begin
                after_r <= ST_OUT;
              end
              fill_r <= '0;
            end
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 1'b1;
          v_r   <= newv;
          tj_r  <= (rnd_r == LOW_ROUNDS) ? T_HIGH_R16 : rotl(tj_r, 1);
          for (int i = 0; i < 15; i++) begin
            win_r[i] <= win_r[i + 1];
          end
          win_r[15] <= wnew;
          if (last_rnd) begin
            for (int i = 0; i < 8; i++) begin
              cv_r[i] <= cv_r[i] ^ newv[i];
            end
          end
        end
        ST_LEN: begin
          for (int i = 0; i < 14; i++) begin
            win_r[i] <= '0;
          end
          win_r[14] <= len_r[63:32];
          win_r[15] <= len_r[31:0];
          after_r   <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            widx_r <= widx_r + 1'b1;
            if (widx_r == 3'd7) begin
              cv_r  <= SM3_IV;
              len_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sm3_hash_engine_top.sv -----
// channel | direction | ports                                          | accepted when
// in      | input     | in_operation, in_data_byte                     | in_valid & in_ready
// out     | output    | out_digest_word, out_word_index, out_last_word | out_valid & out_ready
//
// an absorb item is taken by the round sequencer in its idle state; the 64th byte of a block
// starts the rounds, one round per cycle through a single round unit
// finalize runs the rounds of the padded block, and of a second block when the length spills into it,
// then the eight digest words go out in order, each when out_ready is high
// the input queue keeps taking items until it is full while the sequencer runs rounds or waits on out
// rst_n is synchronous; it empties the queue and loads the initial vector
module sm3_hash_engine_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sm3_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_pop;

  // pack the item for the queue
  assign in_item.operation = op_t'(in_operation);
  assign in_item.data_byte = in_data_byte;

  // front: item queue between the port and the sequencer
  sm3_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: block buffer, message expansion window, rounds and digest output
  sm3_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ----- hw/rtl/sm3_checker.sv -----
module sm3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // last flag marks exactly the eighth word
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest_word)
      && $stable(out_word_index)))
    else $error("stalled digest word changed");

  // words of one digest follow back to back in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == 3'($past(out_word_index) + 3'd1)))
    else $error("digest words out of order");

endmodule

bind sm3_hash_engine_top sm3_checker u_sm3_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);

// ----- tb/sv/sm3_digest_checker.sv -----
module sm3_digest_checker
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          words_pending,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  digest_word_t digest_q[$];

  logic [31:0] chain_v [8];
  logic [7:0]  msg_block [64];
  int unsigned fill_cnt;
  logic [63:0] bit_len;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    n = n % 32;
    if (n == 0) return v;
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(logic [31:0] v);
    return v ^ rol32(v, 9) ^ rol32(v, 17);
  endfunction

  function automatic logic [31:0] perm1(logic [31:0] v);
    return v ^ rol32(v, 15) ^ rol32(v, 23);
  endfunction

  task automatic compress_block();
    logic [31:0] w [68];
    logic [31:0] wp [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = perm1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 64; j++)
      wp[j] = w[j] ^ w[j+4];
    {a, b, c, d, e, f, g, h} = {chain_v[0], chain_v[1], chain_v[2], chain_v[3],
                                chain_v[4], chain_v[5], chain_v[6], chain_v[7]};
    for (int j = 0; j < 64; j++) begin
      t   = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rol32(a, 12);
      ss1 = rol32(a12 + e + rol32(t, j), 7);
      ss2 = ss1 ^ a12;
      ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
      gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
      tt1 = ff + d + ss2 + wp[j];
      tt2 = gg + h + ss1 + w[j];
      d = c;
      c = rol32(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rol32(f, 19);
      f = e;
      e = perm0(tt2);
    end
    chain_v[0] ^= a; chain_v[1] ^= b; chain_v[2] ^= c; chain_v[3] ^= d;
    chain_v[4] ^= e; chain_v[5] ^= f; chain_v[6] ^= g; chain_v[7] ^= h;
  endtask

  task automatic restart_hash();
    chain_v = SM3_IV;
    foreach (msg_block[i]) msg_block[i] = 8'h00;
    fill_cnt = 0;
    bit_len  = '0;
  endtask

  task automatic predict_item(logic op, logic [7:0] data);
    int unsigned pos;
    digest_word_t dw;
    if (op == OP_ABSORB) begin
      msg_block[fill_cnt] = data;
      bit_len += 64'd8;
      fill_cnt++;
      if (fill_cnt == 64) begin
        compress_block();
        fill_cnt = 0;
      end
    end else begin
      pos = fill_cnt;
      msg_block[pos] = 8'h80;
      for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
      // no room for the length, it goes in an extra block
      if (pos + 1 > 56) begin
        compress_block();
        foreach (msg_block[i]) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = bit_len[8*(7-i) +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain_v[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        digest_q.push_back(dw);
      end
      restart_hash();
    end
  endtask

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
    restart_hash();
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      digest_q.delete();
      restart_hash();
    end else begin
      if (in_valid && in_ready) predict_item(in_operation, in_data_byte);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest word %h idx %0d last %0b",
                     out_digest_word, out_word_index, out_last_word);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_digest_word !== exp_w.word || out_word_index !== exp_w.idx ||
              out_last_word !== exp_w.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                       exp_w.word, exp_w.idx, exp_w.last,
                       out_digest_word, out_word_index, out_last_word);
          end
        end
      end
    end
    words_pending <= digest_q.size();
  end

endmodule

// ----- tb/sv/sm3_hash_engine_top_tb.sv -----
module sm3_hash_engine_top_tb;
  import sm3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = OP_ABSORB;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int words_pending;
  int mismatch_count;
  int items_sent;
  // when set, neither side inserts idle cycles
  bit burst_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sm3_hash_engine_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_data_byte,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word
  );

  sm3_digest_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_data_byte,
    .out_valid, .out_ready, .out_digest_word, .out_word_index, .out_last_word,
    .words_pending, .mismatch_count
  );

  // send one item, with a random idle gap in front of it
  task automatic send_item(logic op, logic [7:0] data);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    // look at ready mid-cycle, where it holds its value for the coming edge
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    // data byte on finalize is don't-care, so make it random
    send_item(OP_FINAL, 8'($urandom_range(0, 255)));
  endtask

  // hold off the sender until every digest word has come out
  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // result side: random stall before each digest word
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    int len;
    items_sent = 0;
    burst_mode = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message gives the standard empty-string digest
    send_item(OP_FINAL, 8'hff);
    // "abc" test vector
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINAL, 8'h00);
    drain_digests();
    // byte extremes and alternating bit patterns
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_ABSORB, 8'h55);
    send_item(OP_ABSORB, 8'haa);
    send_item(OP_FINAL, 8'h5a);

    // random messages, many near the padding boundary and the block edge
    while (items_sent < 500) begin
      burst_mode = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 3))
        0: len = $urandom_range(54, 66);
        1: len = $urandom_range(0, 130);
        default: len = $urandom_range(0, 20);
      endcase
      send_message(len);
      if ($urandom_range(0, 4) == 0) drain_digests();
    end
    burst_mode = 0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sm3_hash_engine_top.f -----
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_front.sv
hw/rtl/sm3_core.sv
hw/rtl/sm3_hash_engine_top.sv
hw/rtl/sm3_checker.sv
tb/sv/sm3_digest_checker.sv
tb/sv/sm3_hash_engine_top_tb.sv
